FILE: rtl/midpoint_ellipse_point_generator_top_defines.svh
// Assertion macros for the midpoint ellipse point generator.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef MIDPOINT_ELLIPSE_POINT_GENERATOR_TOP_DEFINES_SVH
`define MIDPOINT_ELLIPSE_POINT_GENERATOR_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define MEPG_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mepg: same-cycle check failed");
`define MEPG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mepg: next-cycle check failed");
`else
`define MEPG_ASSERT_SAME(lbl, ante, cons)
`define MEPG_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: rtl/mepg_pkg.sv
// Shared types and codes for the midpoint ellipse point generator.
// No dependencies; imported by the controller, datapath and top level.
`default_nettype none

package mepg_pkg;

  // input action codes
  localparam logic ACT_START   = 1'b0;
  localparam logic ACT_ADVANCE = 1'b1;

  // multiplier operand A selects
  typedef logic [2:0] mepg_asel_t;
  localparam mepg_asel_t MA_A    = 3'd0;
  localparam mepg_asel_t MA_B    = 3'd1;
  localparam mepg_asel_t MA_AA   = 3'd2;
  localparam mepg_asel_t MA_BB   = 3'd3;
  localparam mepg_asel_t MA_H    = 3'd4;
  localparam mepg_asel_t MA_YM   = 3'd5;
  localparam mepg_asel_t MA_PROD = 3'd6;

  // multiplier operand B selects
  typedef logic [3:0] mepg_bsel_t;
  localparam mepg_bsel_t MB_A      = 4'd0;
  localparam mepg_bsel_t MB_B      = 4'd1;
  localparam mepg_bsel_t MB_AA     = 4'd2;
  localparam mepg_bsel_t MB_BB     = 4'd3;
  localparam mepg_bsel_t MB_X1     = 4'd4;   // x+1
  localparam mepg_bsel_t MB_2Y1    = 4'd5;   // 2y-1
  localparam mepg_bsel_t MB_2X3    = 4'd6;   // 2x+3
  localparam mepg_bsel_t MB_2M2Y   = 4'd7;   // 2-2y, signed
  localparam mepg_bsel_t MB_3M2Y   = 4'd8;   // 3-2y, signed
  localparam mepg_bsel_t MB_2X2    = 4'd9;   // 2x+2
  localparam mepg_bsel_t MB_H      = 4'd10;  // 2x+1
  localparam mepg_bsel_t MB_YM     = 4'd11;  // y-1

  // decision value updates
  typedef logic [2:0] mepg_dvop_t;
  localparam mepg_dvop_t DV_HOLD  = 3'd0;
  localparam mepg_dvop_t DV_START = 3'd1;  // 4bb + aa - 4*prod
  localparam mepg_dvop_t DV_SET   = 3'd2;  // prod
  localparam mepg_dvop_t DV_ADD4  = 3'd3;  // dv + 4*prod
  localparam mepg_dvop_t DV_SUB4  = 3'd4;  // dv - 4*prod

  // mirror order of the four points of a step
  typedef logic [1:0] mepg_mir_t;
  localparam mepg_mir_t MIR_PP = 2'd0;  // ( x,  y)
  localparam mepg_mir_t MIR_NN = 2'd1;  // (-x, -y)
  localparam mepg_mir_t MIR_NP = 2'd2;  // (-x,  y)
  localparam mepg_mir_t MIR_PN = 2'd3;  // ( x, -y)

  typedef struct packed {
    logic       load_in;
    mepg_asel_t mul_a;
    mepg_bsel_t mul_b;
    mepg_dvop_t dv_op;
    logic       load_aa;
    logic       load_bb;
    logic       load_tmp;
    logic       load_cmp;
    logic       inc_x;
    logic       dec_y;
    logic       out_load;
    mepg_mir_t  out_idx;
    logic       out_last;
  } mepg_cmd_t;

  typedef struct packed {
    logic lt;        // registered region 1 test
    logic dv_pos;    // decision value > 0
    logic y_zero;
    logic out_free;  // output register can take a point this cycle
  } mepg_stat_t;

endpackage

`default_nettype wire

FILE: rtl/mepg_in_if.sv
// Input channel of the midpoint ellipse point generator: valid/ready plus item.
// No dependencies.
`default_nettype none

interface mepg_in_if #(
  parameter int COORD_WIDTH = 12
) ();
  logic                   valid;
  logic                   ready;
  logic                   action;
  logic [COORD_WIDTH-1:0] corner_one_x;
  logic [COORD_WIDTH-1:0] corner_one_y;
  logic [COORD_WIDTH-1:0] corner_two_x;
  logic [COORD_WIDTH-1:0] corner_two_y;

  modport source (
    output valid, action, corner_one_x, corner_one_y, corner_two_x, corner_two_y,
    input  ready
  );
  modport sink (
    input  valid, action, corner_one_x, corner_one_y, corner_two_x, corner_two_y,
    output ready
  );
endinterface

`default_nettype wire

FILE: rtl/mepg_out_if.sv
// Result channel of the midpoint ellipse point generator: valid/ready plus point.
// No dependencies.
`default_nettype none

interface mepg_out_if #(
  parameter int COORD_WIDTH = 12
) ();
  logic                        valid;
  logic                        ready;
  logic signed [COORD_WIDTH:0] point_x;
  logic signed [COORD_WIDTH:0] point_y;
  logic                        final_point;

  modport source (
    output valid, point_x, point_y, final_point,
    input  ready
  );
  modport sink (
    input  valid, point_x, point_y, final_point,
    output ready
  );
endinterface

`default_nettype wire

FILE: rtl/midpoint_ellipse_point_generator_top.sv
// Top level of the midpoint ellipse point generator: controller plus datapath.
// Depends on mepg_pkg, mepg_in_if, mepg_out_if, mepg_ctrl, mepg_datapath.
`default_nettype none
`include "midpoint_ellipse_point_generator_top_defines.svh"

// Rasterizes an origin-centered ellipse by the two-region midpoint method. A
// start item (action 0) sets the semi-axes from two corners and yields the four
// mirrored points of (0,b); each advance item (action 1) takes one step and
// yields four points, the last point of the step that reaches y = 0 carrying
// final_point. Advances before any start or after the final step are taken
// and produce nothing. Items are handled one at a time; the input is ready
// only while the sequencer is idle. All products come from a single shared
// multiplier, one per cycle. The four points of an item are driven out
// through the output register at one per cycle while the output is free.
// A stalled output holds the sequencer on the point it is about to load;
// once the fourth point sits in the output register the next item is
// accepted while that point waits.
module midpoint_ellipse_point_generator_top import mepg_pkg::*; #(
  parameter int COORD_WIDTH = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  mepg_in_if.sink     in_item,
  mepg_out_if.source  out_item
);

  mepg_cmd_t  cmd;
  mepg_stat_t stat;

  mepg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_item.valid),
    .in_action (in_item.action),
    .in_ready  (in_item.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  mepg_datapath #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_corner_one_x (in_item.corner_one_x),
    .in_corner_one_y (in_item.corner_one_y),
    .in_corner_two_x (in_item.corner_two_x),
    .in_corner_two_y (in_item.corner_two_y),
    .cmd             (cmd),
    .stat            (stat),
    .out_valid       (out_item.valid),
    .out_ready       (out_item.ready),
    .out_point_x     (out_item.point_x),
    .out_point_y     (out_item.point_y),
    .out_final_point (out_item.final_point)
  );

  // a start transfer loads the axes in the same cycle
  `MEPG_ASSERT_SAME(a_start_loads,
                    in_item.valid && in_item.ready && (in_item.action == ACT_START),
                    cmd.load_in)
  // no point is loaded while a new item can be taken
  `MEPG_ASSERT_SAME(a_idle_no_emit, in_item.ready, !cmd.out_load)
  // the final point is the (x,-y) mirror of a point with y = 0
  `MEPG_ASSERT_SAME(a_final_on_axis, out_item.valid && out_item.final_point, out_item.point_y == '0)
  // a loaded final point shows up on the output
  `MEPG_ASSERT_NEXT(a_final_shown, cmd.out_load && cmd.out_last, out_item.valid && out_item.final_point)

endmodule

`default_nettype wire

FILE: rtl/mepg_ctrl.sv
// Sequencing controller: trace phase, micro-step state and point emission.
// Depends on mepg_pkg; drives the datapath through mepg_cmd_t.
`default_nettype none

module mepg_ctrl import mepg_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_action,
  output logic       in_ready,
  input  mepg_stat_t stat,
  output mepg_cmd_t  cmd
);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_SQA  = 5'd1;
  localparam logic [4:0] S_SQB  = 5'd2;
  localparam logic [4:0] S_AAB  = 5'd3;
  localparam logic [4:0] S_DV0  = 5'd4;
  localparam logic [4:0] S_R1A  = 5'd5;
  localparam logic [4:0] S_R1B  = 5'd6;
  localparam logic [4:0] S_R1C  = 5'd7;
  localparam logic [4:0] S_R1D  = 5'd8;
  localparam logic [4:0] S_R1E  = 5'd9;
  localparam logic [4:0] S_R1F  = 5'd10;
  localparam logic [4:0] S_R1G  = 5'd11;
  localparam logic [4:0] S_R2SA = 5'd12;
  localparam logic [4:0] S_R2SB = 5'd13;
  localparam logic [4:0] S_R2SC = 5'd14;
  localparam logic [4:0] S_R2SD = 5'd15;
  localparam logic [4:0] S_R2SE = 5'd16;
  localparam logic [4:0] S_R2A  = 5'd17;
  localparam logic [4:0] S_R2B  = 5'd18;
  localparam logic [4:0] S_R2C  = 5'd19;
  localparam logic [4:0] S_FIN  = 5'd20;
  localparam logic [4:0] S_EMIT = 5'd21;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_R1   = 2'd1;
  localparam logic [1:0] PH_R2   = 2'd2;
  localparam logic [1:0] PH_DONE = 2'd3;

  logic [4:0] state_r, state_nxt;
  logic [1:0] phase_r, phase_nxt;
  mepg_mir_t  idx_r, idx_nxt;
  logic       last_r, last_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    idx_nxt       = idx_r;
    last_nxt      = last_r;
    cmd           = '0;
    cmd.mul_a     = MA_AA;
    cmd.mul_b     = MB_BB;
    cmd.dv_op     = DV_HOLD;
    cmd.out_idx   = idx_r;
    cmd.out_last  = last_r && (idx_r == MIR_PN);

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_action == ACT_START) begin
            cmd.load_in = 1'b1;
            phase_nxt   = PH_R1;
            state_nxt   = S_SQA;
          end else if (phase_r == PH_R1) begin
            state_nxt = S_R1A;
          end else if (phase_r == PH_R2) begin
            state_nxt = S_R2A;
          end
        end
      end
      // start: aa, bb, then 4bb + aa - 4aab
      S_SQA: begin
        cmd.mul_a = MA_A;
        cmd.mul_b = MB_A;
        state_nxt = S_SQB;
      end
      S_SQB: begin
        cmd.load_aa = 1'b1;
        cmd.mul_a   = MA_B;
        cmd.mul_b   = MB_B;
        state_nxt   = S_AAB;
      end
      S_AAB: begin
        cmd.load_bb = 1'b1;
        cmd.mul_a   = MA_AA;
        cmd.mul_b   = MB_B;
        state_nxt   = S_DV0;
      end
      S_DV0: begin
        cmd.dv_op = DV_START;
        state_nxt = S_FIN;
      end
      // region 1 test: 2bb(x+1) < aa(2y-1)
      S_R1A: begin
        cmd.mul_a = MA_BB;
        cmd.mul_b = MB_X1;
        state_nxt = S_R1B;
      end
      S_R1B: begin
        cmd.load_tmp = 1'b1;
        cmd.mul_a    = MA_AA;
        cmd.mul_b    = MB_2Y1;
        state_nxt    = S_R1C;
      end
      S_R1C: begin
        cmd.load_cmp = 1'b1;
        state_nxt    = S_R1D;
      end
      S_R1D: begin
        if (stat.lt) begin
          cmd.mul_a = MA_BB;
          cmd.mul_b = MB_2X3;
          state_nxt = S_R1E;
        end else begin
          cmd.mul_a = MA_H;
          cmd.mul_b = MB_H;
          state_nxt = S_R2SA;
        end
      end
      S_R1E: begin
        cmd.dv_op = DV_ADD4;
        state_nxt = S_R1F;
      end
      S_R1F: begin
        if (stat.dv_pos) begin
          cmd.mul_a = MA_AA;
          cmd.mul_b = MB_2M2Y;
          state_nxt = S_R1G;
        end else begin
          cmd.inc_x = 1'b1;
          state_nxt = S_FIN;
        end
      end
      S_R1G: begin
        cmd.dv_op = DV_ADD4;
        cmd.dec_y = 1'b1;
        cmd.inc_x = 1'b1;
        state_nxt = S_FIN;
      end
      // region 2 start: bb*h^2 + 4aa*ym^2 - 4aa*bb
      S_R2SA: begin
        cmd.mul_a = MA_PROD;
        cmd.mul_b = MB_BB;
        state_nxt = S_R2SB;
      end
      S_R2SB: begin
        cmd.dv_op = DV_SET;
        cmd.mul_a = MA_YM;
        cmd.mul_b = MB_YM;
        state_nxt = S_R2SC;
      end
      S_R2SC: begin
        cmd.mul_a = MA_PROD;
        cmd.mul_b = MB_AA;
        state_nxt = S_R2SD;
      end
      S_R2SD: begin
        cmd.dv_op = DV_ADD4;
        cmd.mul_a = MA_AA;
        cmd.mul_b = MB_BB;
        state_nxt = S_R2SE;
      end
      S_R2SE: begin
        cmd.dv_op = DV_SUB4;
        phase_nxt = PH_R2;
        state_nxt = S_R2A;
      end
      // region 2 step
      S_R2A: begin
        if (stat.dv_pos) begin
          cmd.mul_a = MA_AA;
          cmd.mul_b = MB_3M2Y;
          state_nxt = S_R2B;
        end else begin
          cmd.mul_a = MA_BB;
          cmd.mul_b = MB_2X2;
          state_nxt = S_R2C;
        end
      end
      S_R2C: begin
        cmd.dv_op = DV_ADD4;
        cmd.inc_x = 1'b1;
        cmd.mul_a = MA_AA;
        cmd.mul_b = MB_3M2Y;
        state_nxt = S_R2B;
      end
      S_R2B: begin
        cmd.dv_op = DV_ADD4;
        cmd.dec_y = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        last_nxt = stat.y_zero;
        if (stat.y_zero) begin
          phase_nxt = PH_DONE;
        end
        idx_nxt   = MIR_PP;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          idx_nxt      = idx_r + 2'd1;
          if (idx_r == MIR_PN) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= PH_IDLE;
      idx_r   <= MIR_PP;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      last_r  <= last_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/mepg_datapath.sv
// Datapath: axes, step point, decision value, shared multiplier, output register.
// Depends on mepg_pkg; controlled by mepg_ctrl through mepg_cmd_t.
`default_nettype none

module mepg_datapath import mepg_pkg::*; #(
  parameter int COORD_WIDTH = 12
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [COORD_WIDTH-1:0]      in_corner_one_x,
  input  logic [COORD_WIDTH-1:0]      in_corner_one_y,
  input  logic [COORD_WIDTH-1:0]      in_corner_two_x,
  input  logic [COORD_WIDTH-1:0]      in_corner_two_y,
  input  mepg_cmd_t                   cmd,
  output mepg_stat_t                  stat,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [COORD_WIDTH:0] out_point_x,
  output logic signed [COORD_WIDTH:0] out_point_y,
  output logic                        out_final_point
);

  localparam int W  = COORD_WIDTH;
  localparam int AW = 2 * COORD_WIDTH + 3;  // holds aa, bb, h^2, ym^2
  localparam int BW = 2 * COORD_WIDTH + 1;  // holds aa, bb, small signed terms
  localparam int DW = AW + BW;              // decision value width

  logic [W-1:0]          a_r, b_r, x_r, y_r;
  logic [2*W-1:0]        aa_r, bb_r;
  logic signed [DW-1:0]  dv_r, tmp_r, prod_r;
  logic                  lt_r;
  logic                  out_valid_r;
  logic signed [W:0]     out_x_r, out_y_r;
  logic                  out_last_r;

  logic [W-1:0]          a_in, b_in, y_m1;
  logic [W:0]            x_p1, two_y_m1, h;
  logic [W+1:0]          y_dbl, two_x_p3, two_x_p2;
  logic signed [W+1:0]   two_m2y, three_m2y;
  logic signed [AW-1:0]  a_op;
  logic signed [BW-1:0]  b_op;
  logic signed [DW-1:0]  prod;
  logic signed [W:0]     px, nx, py, ny;

  assign a_in = (in_corner_one_x > in_corner_two_x) ? in_corner_one_x - in_corner_two_x
                                                    : in_corner_two_x - in_corner_one_x;
  assign b_in = (in_corner_two_y > in_corner_one_y) ? in_corner_two_y - in_corner_one_y
                                                    : in_corner_one_y - in_corner_two_y;

  assign x_p1      = {1'b0, x_r} + (W+1)'(1);
  assign h         = {x_r, 1'b1};
  assign two_y_m1  = {y_r, 1'b0} - (W+1)'(1);
  assign y_m1      = y_r - W'(1);
  assign y_dbl     = {1'b0, y_r, 1'b0};
  assign two_x_p3  = {1'b0, x_r, 1'b1} + (W+2)'(2);
  assign two_x_p2  = {1'b0, x_r, 1'b0} + (W+2)'(2);
  assign two_m2y   = $signed((W+2)'(2) - y_dbl);
  assign three_m2y = $signed((W+2)'(3) - y_dbl);

  always_comb begin
    case (cmd.mul_a)
      MA_A:    a_op = AW'(a_r);
      MA_B:    a_op = AW'(b_r);
      MA_AA:   a_op = AW'(aa_r);
      MA_BB:   a_op = AW'(bb_r);
      MA_H:    a_op = AW'(h);
      MA_YM:   a_op = AW'(y_m1);
      MA_PROD: a_op = prod_r[AW-1:0];
      default: a_op = '0;
    endcase
  end

  always_comb begin
    case (cmd.mul_b)
      MB_A:    b_op = BW'(a_r);
      MB_B:    b_op = BW'(b_r);
      MB_AA:   b_op = BW'(aa_r);
      MB_BB:   b_op = BW'(bb_r);
      MB_X1:   b_op = BW'(x_p1);
      MB_2Y1:  b_op = BW'(two_y_m1);
      MB_2X3:  b_op = BW'(two_x_p3);
      MB_2M2Y: b_op = BW'(two_m2y);
      MB_3M2Y: b_op = BW'(three_m2y);
      MB_2X2:  b_op = BW'(two_x_p2);
      MB_H:    b_op = BW'(h);
      MB_YM:   b_op = BW'(y_m1);
      default: b_op = '0;
    endcase
  end

  assign prod = a_op * b_op;

  // product is consumed the cycle after its operands are selected
  always_ff @(posedge clk) begin
    prod_r <= prod;
    if (cmd.load_in) begin
      a_r <= a_in;
      b_r <= b_in;
      x_r <= '0;
      y_r <= b_in;
    end else begin
      if (cmd.inc_x) x_r <= x_r + W'(1);
      if (cmd.dec_y) y_r <= y_r - W'(1);
    end
    if (cmd.load_aa)  aa_r  <= prod_r[2*W-1:0];
    if (cmd.load_bb)  bb_r  <= prod_r[2*W-1:0];
    if (cmd.load_tmp) tmp_r <= prod_r;
    if (cmd.load_cmp) lt_r  <= ((tmp_r <<< 1) < prod_r);
    case (cmd.dv_op)
      DV_START: dv_r <= (DW'(bb_r) << 2) + DW'(aa_r) - (prod_r <<< 2);
      DV_SET:   dv_r <= prod_r;
      DV_ADD4:  dv_r <= dv_r + (prod_r <<< 2);
      DV_SUB4:  dv_r <= dv_r - (prod_r <<< 2);
      default:  dv_r <= dv_r;
    endcase
  end

  assign px = {1'b0, x_r};
  assign nx = -px;
  assign py = {1'b0, y_r};
  assign ny = -py;

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      case (cmd.out_idx)
        MIR_PP: begin
          out_x_r <= px;
          out_y_r <= py;
        end
        MIR_NN: begin
          out_x_r <= nx;
          out_y_r <= ny;
        end
        MIR_NP: begin
          out_x_r <= nx;
          out_y_r <= py;
        end
        default: begin
          out_x_r <= px;
          out_y_r <= ny;
        end
      endcase
      out_last_r <= cmd.out_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign stat.lt       = lt_r;
  assign stat.dv_pos   = !dv_r[DW-1] && (dv_r != '0);
  assign stat.y_zero   = (y_r == '0);
  assign stat.out_free = !out_valid_r || out_ready;

  assign out_valid       = out_valid_r;
  assign out_point_x     = out_x_r;
  assign out_point_y     = out_y_r;
  assign out_final_point = out_last_r;

endmodule

`default_nettype wire

FILE: tb/sv/midpoint_ellipse_point_generator_top_tb.sv
// Testbench for midpoint_ellipse_point_generator_top: random and directed ellipse traces.
// Predicts mirrored points in a scoreboard class and checks each output transfer.
// Depends on mepg_pkg, mepg_in_if, mepg_out_if and the RTL top level.
`default_nettype none

module midpoint_ellipse_point_generator_top_tb;
  import mepg_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW           = 12;
  localparam int ITEM_TARGET  = 360;
  localparam int PRESSURE_AT  = 250;
  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 3000;
  localparam int DRAIN_CYCLES = 40;
  localparam int COORD_MAX    = (1 << CW) - 1;

  typedef bit [63:0] wide_t;
  typedef logic [CW-1:0] coord_t;

  localparam wide_t COORD_MASK = (64'd1 << CW) - 64'd1;

  typedef enum logic [1:0] {TRACE_IDLE, TRACE_R1, TRACE_R2, TRACE_DONE} trace_phase_t;

  typedef struct packed {
    logic   action;
    coord_t c1x;
    coord_t c1y;
    coord_t c2x;
    coord_t c2y;
  } ellipse_item_t;

  typedef struct packed {
    logic signed [CW:0] point_x;
    logic signed [CW:0] point_y;
    logic               final_point;
  } ellipse_point_t;

  class ellipse_scoreboard;
    wide_t          axis_a, axis_b, cur_x, cur_y, dv;
    trace_phase_t   phase;
    ellipse_point_t expected_points[$];
    int             errors;

    function new();
      axis_a = 0;
      axis_b = 0;
      cur_x  = 0;
      cur_y  = 0;
      dv     = 0;
      phase  = TRACE_IDLE;
      errors = 0;
    endfunction

    function bit trace_active();
      return phase == TRACE_R1 || phase == TRACE_R2;
    endfunction

    function bit dv_positive();
      return !dv[63] && dv != 0;
    endfunction

    // mirror order: (x,y), (-x,-y), (-x,y), (x,-y)
    function void queue_mirrors(bit last);
      wide_t neg_x, neg_y;
      neg_x = 64'd0 - cur_x;
      neg_y = 64'd0 - cur_y;
      expected_points.push_back('{cur_x[CW:0], cur_y[CW:0], 1'b0});
      expected_points.push_back('{neg_x[CW:0], neg_y[CW:0], 1'b0});
      expected_points.push_back('{neg_x[CW:0], cur_y[CW:0], 1'b0});
      expected_points.push_back('{cur_x[CW:0], neg_y[CW:0], last});
    endfunction

    // Returns the number of points the accepted item should produce.
    function int predict_points(ellipse_item_t it);
      wide_t aa, bb, h, ym;
      bit    last;
      if (it.action == ACT_START) begin
        axis_a = (it.c1x > it.c2x) ? wide_t'(it.c1x - it.c2x) : wide_t'(it.c2x - it.c1x);
        axis_b = (it.c2y > it.c1y) ? wide_t'(it.c2y - it.c1y) : wide_t'(it.c1y - it.c2y);
        aa     = axis_a * axis_a;
        bb     = axis_b * axis_b;
        cur_x  = 0;
        cur_y  = axis_b;
        dv     = 64'd4 * bb + aa - 64'd4 * aa * axis_b;
        last   = (axis_b == 0);
        phase  = last ? TRACE_DONE : TRACE_R1;
        queue_mirrors(last);
        return 4;
      end
      if (!trace_active()) return 0;
      aa = axis_a * axis_a;
      bb = axis_b * axis_b;
      if (phase == TRACE_R1) begin
        if (64'd2 * bb * (cur_x + 64'd1) < aa * (64'd2 * cur_y - 64'd1)) begin
          dv = dv + 64'd4 * bb * (64'd2 * cur_x + 64'd3);
          if (dv_positive()) begin
            dv    = dv + 64'd4 * aa * (64'd2 - 64'd2 * cur_y);
            cur_y = cur_y - 64'd1;
          end
          cur_x = cur_x + 64'd1;
        end else begin
          // region 2 opens here and this same advance takes its first step
          h     = 64'd2 * cur_x + 64'd1;
          ym    = cur_y - 64'd1;
          dv    = bb * h * h + 64'd4 * aa * ym * ym - 64'd4 * aa * bb;
          phase = TRACE_R2;
        end
      end
      if (phase == TRACE_R2) begin
        if (dv_positive()) begin
          dv = dv + 64'd4 * aa * (64'd3 - 64'd2 * cur_y);
        end else begin
          dv = dv + 64'd4 * bb * (64'd2 * cur_x + 64'd2) + 64'd4 * aa * (64'd3 - 64'd2 * cur_y);
          cur_x = cur_x + 64'd1;
        end
        cur_y = cur_y - 64'd1;
      end
      cur_x = cur_x & COORD_MASK;
      cur_y = cur_y & COORD_MASK;
      last  = (cur_y == 0);
      if (last) phase = TRACE_DONE;
      queue_mirrors(last);
      return 4;
    endfunction

    function void flag(string what, logic signed [CW:0] want, logic signed [CW:0] got);
      errors++;
      if (errors <= 100) begin
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
      end
    endfunction

    function void check_point(ellipse_point_t got);
      ellipse_point_t want;
      if (expected_points.size() == 0) begin
        errors++;
        if (errors <= 100) begin
          $display("%0t: unexpected point: expected none, actual (%0d, %0d, %0b)",
                   $time, got.point_x, got.point_y, got.final_point);
        end
        return;
      end
      want = expected_points.pop_front();
      if (got.point_x !== want.point_x) flag("point_x", want.point_x, got.point_x);
      if (got.point_y !== want.point_y) flag("point_y", want.point_y, got.point_y);
      if (got.final_point !== want.final_point) begin
        flag("final_point", {{CW{1'b0}}, want.final_point}, {{CW{1'b0}}, got.final_point});
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  mepg_in_if  #(.COORD_WIDTH(CW)) in_item ();
  mepg_out_if #(.COORD_WIDTH(CW)) out_item ();

  midpoint_ellipse_point_generator_top #(.COORD_WIDTH(CW)) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .out_item (out_item)
  );

  ellipse_scoreboard sb = new();
  int busy_items   = 0;  // accepted items that produced points
  int quiet_cycles = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // sender idles 9% then 74% then never; receiver 74% then 9% then never
  function automatic int tx_idle_pct();
    if (busy_items < ITEM_TARGET / 3) return 9;
    if (busy_items < 2 * ITEM_TARGET / 3) return 74;
    return 0;
  endfunction

  function automatic int rx_idle_pct();
    if (busy_items < ITEM_TARGET / 3) return 74;
    if (busy_items < 2 * ITEM_TARGET / 3) return 9;
    return 0;
  endfunction

  task automatic send_item(input ellipse_item_t it);
    while ($urandom_range(0, 99) < tx_idle_pct()) begin
      in_item.valid <= 1'b0;
      @(posedge clk);
    end
    in_item.valid        <= 1'b1;
    in_item.action       <= it.action;
    in_item.corner_one_x <= it.c1x;
    in_item.corner_one_y <= it.c1y;
    in_item.corner_two_x <= it.c2x;
    in_item.corner_two_y <= it.c2y;
    @(posedge clk);
    while (!in_item.ready) @(posedge clk);
    if (sb.predict_points(it) > 0) busy_items++;
  endtask

  // corner fields carry random junk on advances
  task automatic send_advance();
    ellipse_item_t it;
    it.action = ACT_ADVANCE;
    it.c1x    = coord_t'($urandom);
    it.c1y    = coord_t'($urandom);
    it.c2x    = coord_t'($urandom);
    it.c2y    = coord_t'($urandom);
    send_item(it);
  endtask

  task automatic drive_trace(input coord_t c1x, input coord_t c1y, input coord_t c2x,
                             input coord_t c2y, input int max_adv);
    ellipse_item_t it;
    int            n;
    it.action = ACT_START;
    it.c1x    = c1x;
    it.c1y    = c1y;
    it.c2x    = c2x;
    it.c2y    = c2y;
    send_item(it);
    n = 0;
    while (n < max_adv && sb.trace_active()) begin
      send_advance();
      n++;
    end
  endtask

  function automatic void pick_span(input int span, output coord_t p, output coord_t q);
    int lo;
    lo = $urandom_range(0, COORD_MAX - span);
    if ($urandom_range(0, 1)) begin
      p = coord_t'(lo);
      q = coord_t'(lo + span);
    end else begin
      p = coord_t'(lo + span);
      q = coord_t'(lo);
    end
  endfunction

  // receiver: random ready, plus one long hold-off so the block backs up
  initial begin
    int hold_left;
    bit pressure_done;
    hold_left     = 0;
    pressure_done = 0;
    out_item.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_item.ready <= 1'b0;
      end else if (!pressure_done && busy_items >= PRESSURE_AT) begin
        pressure_done = 1;
        hold_left     = HOLD_CYCLES;
        out_item.ready <= 1'b0;
      end else begin
        out_item.ready <= ($urandom_range(0, 99) >= rx_idle_pct());
      end
    end
  end

  always @(posedge clk) begin : mon
    ellipse_point_t got;
    if (rst_n) begin
      if (out_item.valid && out_item.ready) begin
        got.point_x     = out_item.point_x;
        got.point_y     = out_item.point_y;
        got.final_point = out_item.final_point;
        sb.check_point(got);
      end
      if ((in_item.valid && in_item.ready) || (out_item.valid && out_item.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    coord_t px, qx, py, qy;
    int     r, span_x, span_y, max_adv;
    rst_n                <= 1'b0;
    in_item.valid        <= 1'b0;
    in_item.action       <= ACT_START;
    in_item.corner_one_x <= '0;
    in_item.corner_one_y <= '0;
    in_item.corner_two_x <= '0;
    in_item.corner_two_y <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_advance();                                // advance before any start: ignored
    drive_trace(12'd0, 12'd0, 12'd4095, 12'd4095, 3);  // widest ellipse, then abandoned
    drive_trace(12'd300, 12'd50, 12'd100, 12'd50, 0);  // flat: start carries the final point
    send_advance();                                // after done: ignored
    drive_trace(12'd7, 12'd3, 12'd7, 12'd0, 8);    // a = 0 goes straight to region 2
    send_advance();
    drive_trace(12'd0, 12'd1, 12'd4, 12'd0, 8);    // region 1 step lands on y = 0
    drive_trace(12'd6, 12'd2, 12'd2, 12'd5, 30);   // full trace through both regions

    while (busy_items < ITEM_TARGET) begin
      r = $urandom_range(0, 99);
      if (r < 6) begin
        send_advance();
      end else begin
        if (r < 9) begin
          span_x  = $urandom_range(3000, COORD_MAX);
          span_y  = $urandom_range(3000, COORD_MAX);
          max_adv = $urandom_range(0, 12);
        end else if (r < 16) begin
          span_x  = $urandom_range(13, 400);
          span_y  = $urandom_range(13, 400);
          max_adv = $urandom_range(0, 25);
        end else begin
          span_x  = $urandom_range(0, 12);
          span_y  = $urandom_range(0, 12);
          max_adv = ($urandom_range(0, 99) < 85) ? 1000 : $urandom_range(0, 8);
        end
        pick_span(span_x, px, qx);
        pick_span(span_y, py, qy);
        drive_trace(px, py, qx, qy, max_adv);
      end
    end
    in_item.valid <= 1'b0;

    while (sb.expected_points.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.expected_points.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: midpoint_ellipse_point_generator_top.f
+incdir+rtl
rtl/mepg_pkg.sv
rtl/mepg_in_if.sv
rtl/mepg_out_if.sv
rtl/mepg_ctrl.sv
rtl/mepg_datapath.sv
rtl/midpoint_ellipse_point_generator_top.sv
tb/sv/midpoint_ellipse_point_generator_top_tb.sv
